>>> rtl/core/assert_macros.svh
// assert_macros.svh: concurrent assertion helpers used by tfu_checker
// expects i_clk and i_rst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked only outside reset
`define TFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TFU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

>>> rtl/core/tfu_pkg.sv
// tfu_pkg: types, codes and fixed-point formats of the trig function unit
// no dependencies; imported by every module of the unit except tfu_fifo
`default_nettype none

package tfu_pkg;

    localparam int CMD_W     = 3;
    localparam int ANGLE_W   = 24;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_SIN = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TAN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CSC = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEC = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIV0 = 2'd2;

    // working values are Q.24, radians stay at or below 2*pi
    localparam int WORK_FRAC = 24;
    localparam int OUT_FRAC  = 16;
    localparam int RAD_W     = 27;
    localparam int X2_W      = 30;
    localparam int TERM_W    = 32;
    localparam int SUM_W     = 38;
    localparam int MAG_W     = 38;
    localparam int QUO_W     = 33;
    localparam int N_W       = 39;
    localparam int RCP_W     = 40;
    localparam int RCP_HALF  = 20;
    localparam int DIV_D_W   = 10;

    // pi/180 in unsigned Q0.32
    localparam logic [RAD_W-1:0] DEG_TO_RAD_Q32 = 27'd74961321;

    typedef enum logic [2:0] {
        OP_SIN,
        OP_COS,
        OP_TAN,
        OP_CSC,
        OP_SEC,
        OP_COT,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [ANGLE_W-1:0] angle_deg;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic             neg;
        logic [RAD_W-1:0] rad;
    } t_front;

    typedef struct packed {
        t_op                     op;
        logic                    neg;
        logic [X2_W-1:0]         x2;
        logic [TERM_W-1:0]       t_s;
        logic [TERM_W-1:0]       t_c;
        logic signed [SUM_W-1:0] sum_s;
        logic signed [SUM_W-1:0] sum_c;
    } t_work;

    typedef struct packed {
        logic             ratio;
        logic             neg;
        logic             zero;
        logic             ovf;
        t_out             res;
        logic [MAG_W-1:0] den;
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } t_div;

    // sign and saturate a magnitude into Q16.16
    function automatic t_out f_emit(input logic [QUO_W:0] mag, input logic neg);
        t_out r;
        r.status = ST_OK;
        if (!neg && mag > (QUO_W+1)'(32'h7fff_ffff)) begin
            r.value  = 32'h7fff_ffff;
            r.status = ST_SAT;
        end else if (neg && mag > (QUO_W+1)'(32'h8000_0000)) begin
            r.value  = 32'h8000_0000;
            r.status = ST_SAT;
        end else if (neg) begin
            r.value = VALUE_W'(32'd0 - mag[VALUE_W-1:0]);
        end else begin
            r.value = mag[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tfu_fifo.sv
// tfu_fifo: small register queue with full and empty flags
// no dependencies; used between front and back and at the result side
`default_nettype none

module tfu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfu_front.sv
// tfu_front: accepts items, clamps the angle, converts to radians, decodes the function
// depends on tfu_pkg
`default_nettype none

module tfu_front import tfu_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    output logic   o_full,
    input  t_in    i_item,
    input  logic   i_q_full,
    output logic   o_q_push,
    output t_front o_q_data
);

    localparam int ANGLE_LIMIT = 360 << ANGLE_FRAC_BITS;
    localparam int RAD_SHIFT   = ANGLE_FRAC_BITS + 32 - WORK_FRAC;
    localparam int PROD_W      = ANGLE_W + RAD_W;

    logic                r_valid;
    t_front              r_data;
    t_front              n_data;
    logic                load;
    logic signed [31:0]  deg_ext;
    logic signed [31:0]  deg_clamped;
    logic [31:0]         deg_abs;
    logic [ANGLE_W-1:0]  deg_mag;
    logic [PROD_W-1:0]   prod_rnd;

    always_comb begin
        deg_ext = 32'(i_item.angle_deg);
        if (deg_ext > ANGLE_LIMIT) begin
            deg_clamped = ANGLE_LIMIT;
        end else if (deg_ext < -ANGLE_LIMIT) begin
            deg_clamped = -ANGLE_LIMIT;
        end else begin
            deg_clamped = deg_ext;
        end
        deg_abs  = (deg_clamped < 0) ? 32'(32'sd0 - deg_clamped) : 32'(deg_clamped);
        deg_mag  = deg_abs[ANGLE_W-1:0];
        prod_rnd = PROD_W'(deg_mag) * PROD_W'(DEG_TO_RAD_Q32)
                 + (PROD_W'(1) << (RAD_SHIFT - 1));
        n_data.rad = RAD_W'(prod_rnd >> RAD_SHIFT);
        n_data.neg = (deg_clamped < 0);
        unique case (i_item.command)
            CMD_SIN: n_data.op = OP_SIN;
            CMD_COS: n_data.op = OP_COS;
            CMD_TAN: n_data.op = OP_TAN;
            CMD_CSC: n_data.op = OP_CSC;
            CMD_SEC: n_data.op = OP_SEC;
            CMD_COT: n_data.op = OP_COT;
            default: n_data.op = OP_NONE;
        endcase
    end

    assign load     = !r_valid || !i_q_full;
    assign o_full   = r_valid && i_q_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_push) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tfu_term.sv
// tfu_term: one series term step for both sine and cosine lanes, four stages
// depends on tfu_pkg; divides by the factorial step through a reciprocal
`default_nettype none

module tfu_term import tfu_pkg::*; #(
    parameter int K = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work
);

    localparam int A       = 2 * K;
    localparam int D_S     = A * (A + 1);
    localparam int D_C     = (A - 1) * A;
    localparam int PROD_W  = TERM_W + X2_W;
    localparam int FULL_W  = N_W + RCP_W;
    localparam int PP_W    = N_W + RCP_HALF;
    localparam logic [RCP_W-1:0] RCP_S = RCP_W'((64'd1 << N_W) / D_S);
    localparam logic [RCP_W-1:0] RCP_C = RCP_W'((64'd1 << N_W) / D_C);
    localparam logic [DIV_D_W-1:0] DV_S = DIV_D_W'(D_S);
    localparam logic [DIV_D_W-1:0] DV_C = DIV_D_W'(D_C);
    localparam logic [N_W-1:0] HALF_S = N_W'(D_S / 2);
    localparam logic [N_W-1:0] HALF_C = N_W'(D_C / 2);
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (WORK_FRAC - 1);
    localparam bit SUBTRACT = (K % 2) == 1;

    // stage a: term times x squared
    logic              r_va;
    t_work             r_wa;
    logic [PROD_W-1:0] r_ps, r_pc;
    // stage b: rounded numerator and reciprocal partial products
    logic              r_vb;
    t_work             r_wb;
    logic [N_W-1:0]    r_nbs, r_nbc;
    logic [PP_W-1:0]   r_pls, r_phs, r_plc, r_phc;
    logic [N_W-1:0]    n_nbs, n_nbc;
    // stage c: quotient estimate
    logic              r_vc;
    t_work             r_wc;
    logic [N_W-1:0]    r_ncs, r_ncc;
    logic [N_W-1:0]    r_qs, r_qc;
    logic [FULL_W-1:0] full_s, full_c;
    // stage d: corrected quotient and new sums
    logic              r_vd;
    t_work             r_wd;
    t_work             n_wd;
    logic [N_W-1:0]    rem_s, rem_c;
    logic [N_W-1:0]    q_s, q_c;

    assign n_nbs  = N_W'((r_ps + RND) >> WORK_FRAC) + HALF_S;
    assign n_nbc  = N_W'((r_pc + RND) >> WORK_FRAC) + HALF_C;
    assign full_s = (FULL_W'(r_phs) << RCP_HALF) + FULL_W'(r_pls);
    assign full_c = (FULL_W'(r_phc) << RCP_HALF) + FULL_W'(r_plc);

    always_comb begin
        rem_s = r_ncs - N_W'(r_qs * DV_S);
        rem_c = r_ncc - N_W'(r_qc * DV_C);
        // estimate is low by at most one
        q_s = (rem_s >= N_W'(DV_S)) ? r_qs + 1'b1 : r_qs;
        q_c = (rem_c >= N_W'(DV_C)) ? r_qc + 1'b1 : r_qc;
        n_wd     = r_wc;
        n_wd.t_s = TERM_W'(q_s);
        n_wd.t_c = TERM_W'(q_c);
        if (SUBTRACT) begin
            n_wd.sum_s = r_wc.sum_s - $signed(SUM_W'(q_s));
            n_wd.sum_c = r_wc.sum_c - $signed(SUM_W'(q_c));
        end else begin
            n_wd.sum_s = r_wc.sum_s + $signed(SUM_W'(q_s));
            n_wd.sum_c = r_wc.sum_c + $signed(SUM_W'(q_c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wa  <= i_work;
            r_ps  <= PROD_W'(i_work.t_s) * PROD_W'(i_work.x2);
            r_pc  <= PROD_W'(i_work.t_c) * PROD_W'(i_work.x2);
            r_wb  <= r_wa;
            r_nbs <= n_nbs;
            r_nbc <= n_nbc;
            r_pls <= PP_W'(n_nbs) * PP_W'(RCP_S[RCP_HALF-1:0]);
            r_phs <= PP_W'(n_nbs) * PP_W'(RCP_S[RCP_W-1:RCP_HALF]);
            r_plc <= PP_W'(n_nbc) * PP_W'(RCP_C[RCP_HALF-1:0]);
            r_phc <= PP_W'(n_nbc) * PP_W'(RCP_C[RCP_W-1:RCP_HALF]);
            r_wc  <= r_wb;
            r_ncs <= r_nbs;
            r_ncc <= r_nbc;
            r_qs  <= N_W'(full_s >> N_W);
            r_qc  <= N_W'(full_c >> N_W);
            r_wd  <= n_wd;
        end
    end

    assign o_valid = r_vd;
    assign o_work  = r_wd;

endmodule

`default_nettype wire

>>> rtl/core/tfu_back.sv
// tfu_back: series pipeline, quotient pipeline and result formatting
// depends on tfu_pkg and tfu_term; advances as a whole while i_en is high
`default_nettype none

module tfu_back import tfu_pkg::*; #(
    parameter int SERIES_TERMS = 10
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_front i_front,
    output logic   o_valid,
    output t_out   o_item
);

    localparam int SQ_W  = 2 * RAD_W;
    localparam int NUM_W = MAG_W + OUT_FRAC + 1;
    localparam int CMP_W = MAG_W + QUO_W;

    function automatic t_div f_div_step(input t_div d);
        t_div           o;
        logic [MAG_W:0] sh;
        logic [MAG_W:0] dd;
        o  = d;
        sh = {d.rem, d.nq[QUO_W-1]};
        dd = {1'b0, d.den};
        if (sh >= dd) begin
            sh   = sh - dd;
            o.nq = {d.nq[QUO_W-2:0], 1'b1};
        end else begin
            o.nq = {d.nq[QUO_W-2:0], 1'b0};
        end
        o.rem = sh[MAG_W-1:0];
        return o;
    endfunction

    // first term of both series
    logic            r_v0;
    t_work           r_w0;
    logic [SQ_W-1:0] sq;

    assign sq = SQ_W'(i_front.rad) * SQ_W'(i_front.rad) + (SQ_W'(1) << (WORK_FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w0.op    <= i_front.op;
            r_w0.neg   <= i_front.neg;
            r_w0.x2    <= X2_W'(sq >> WORK_FRAC);
            r_w0.t_s   <= TERM_W'(i_front.rad);
            r_w0.t_c   <= TERM_W'(1) << WORK_FRAC;
            r_w0.sum_s <= $signed(SUM_W'(i_front.rad));
            r_w0.sum_c <= $signed(SUM_W'(1) << WORK_FRAC);
        end
    end

    t_work w_term [SERIES_TERMS];
    logic  v_term [SERIES_TERMS];

    assign w_term[0] = r_w0;
    assign v_term[0] = r_v0;

    for (genvar k = 1; k < SERIES_TERMS; k++) begin : g_term
        tfu_term #(
            .K (k)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (v_term[k-1]),
            .i_work  (w_term[k-1]),
            .o_valid (v_term[k]),
            .o_work  (w_term[k])
        );
    end

    // pick operands, format sine and cosine, set up the quotient
    t_work                   w_last;
    t_div                    n_dp;
    logic signed [SUM_W-1:0] s_val;
    logic signed [SUM_W-1:0] c_val;
    logic signed [SUM_W-1:0] sc_val;
    logic [MAG_W-1:0]        s_mag;
    logic [MAG_W-1:0]        c_mag;
    logic [MAG_W-1:0]        sc_mag;
    logic [MAG_W-1:0]        num;
    logic [NUM_W-1:0]        num_rnd;

    assign w_last = w_term[SERIES_TERMS-1];

    always_comb begin
        s_val  = w_last.neg ? SUM_W'(0) - w_last.sum_s : w_last.sum_s;
        c_val  = w_last.sum_c;
        s_mag  = MAG_W'((s_val < 0) ? SUM_W'(0) - s_val : s_val);
        c_mag  = MAG_W'((c_val < 0) ? SUM_W'(0) - c_val : c_val);
        sc_val = (w_last.op == OP_SIN) ? s_val : c_val;
        sc_mag = (w_last.op == OP_SIN) ? s_mag : c_mag;
        n_dp.res = f_emit((QUO_W+1)'((sc_mag + (MAG_W'(1) << (WORK_FRAC - OUT_FRAC - 1)))
                                     >> (WORK_FRAC - OUT_FRAC)), sc_val < 0);
        n_dp.ratio = 1'b1;
        unique case (w_last.op)
            OP_SIN, OP_COS: begin
                n_dp.ratio = 1'b0;
                num        = '0;
                n_dp.den   = '0;
                n_dp.neg   = 1'b0;
            end
            OP_TAN: begin
                num      = s_mag;
                n_dp.den = c_mag;
                n_dp.neg = (s_val < 0) != (c_val < 0);
            end
            OP_CSC: begin
                num      = MAG_W'(1) << WORK_FRAC;
                n_dp.den = s_mag;
                n_dp.neg = s_val < 0;
            end
            OP_SEC: begin
                num      = MAG_W'(1) << WORK_FRAC;
                n_dp.den = c_mag;
                n_dp.neg = c_val < 0;
            end
            OP_COT: begin
                num      = c_mag;
                n_dp.den = s_mag;
                n_dp.neg = (s_val < 0) != (c_val < 0);
            end
            default: begin
                // unused codes give zero with ok status
                n_dp.ratio = 1'b0;
                num        = '0;
                n_dp.den   = '0;
                n_dp.neg   = 1'b0;
                n_dp.res   = '{value: '0, status: ST_OK};
            end
        endcase
        num_rnd   = (NUM_W'(num) << OUT_FRAC) + NUM_W'(n_dp.den >> 1);
        n_dp.zero = (n_dp.den == '0);
        // quotient of 2^33 or more always saturates
        n_dp.ovf  = CMP_W'(num_rnd) >= (CMP_W'(n_dp.den) << QUO_W);
        n_dp.rem  = MAG_W'(num_rnd >> QUO_W);
        n_dp.nq   = num_rnd[QUO_W-1:0];
    end

    logic r_vp;
    t_div r_dp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else if (i_en) begin
            r_vp <= v_term[SERIES_TERMS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dp <= n_dp;
        end
    end

    // restoring divider, one quotient bit per stage
    t_div             r_dv  [QUO_W];
    t_div             d_src [QUO_W];
    logic [QUO_W-1:0] r_vv;

    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        if (i == 0) begin : g_first
            assign d_src[i] = r_dp;
        end else begin : g_next
            assign d_src[i] = r_dv[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv <= '0;
        end else if (i_en) begin
            r_vv <= {r_vv[QUO_W-2:0], r_vp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < QUO_W; i++) begin
                r_dv[i] <= f_div_step(d_src[i]);
            end
        end
    end

    // result register
    t_div           d_fin;
    t_out           n_out;
    logic [QUO_W:0] q_mag;
    logic           r_vo;
    t_out           r_out;

    assign d_fin = r_dv[QUO_W-1];

    always_comb begin
        q_mag = d_fin.ovf ? (QUO_W+1)'(1) << QUO_W : {1'b0, d_fin.nq};
        if (!d_fin.ratio) begin
            n_out = d_fin.res;
        end else if (d_fin.zero) begin
            n_out = '{value: '0, status: ST_DIV0};
        end else begin
            n_out = f_emit(q_mag, d_fin.neg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vo;
    assign o_item  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/taylor_trig_function_unit_top.sv
// throughput: one item per cycle while the result queue is not full; each series term takes
// four pipeline stages and the quotient one stage per bit, 33 in all, so neither loop limits the rate
// reset: synchronous active low, clears the queues and all stage valid bits
// top level: front stage, decoupling queue, back pipeline and result queue
// depends on tfu_pkg, tfu_fifo, tfu_front and tfu_back
`default_nettype none

module taylor_trig_function_unit_top import tfu_pkg::*; #(
    parameter int SERIES_TERMS    = 10,
    parameter int ANGLE_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_item
);

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    t_front                      f_data;
    logic                        f_push;
    logic                        mq_full;
    logic                        mq_empty;
    logic [$bits(t_front)-1:0]   mq_data;
    logic                        back_en;
    logic                        b_valid;
    t_out                        b_item;
    logic                        oq_full;
    logic [$bits(t_out)-1:0]     oq_data;

    tfu_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_full (mq_full),
        .o_q_push (f_push),
        .o_q_data (f_data)
    );

    tfu_fifo #(
        .WIDTH ($bits(t_front)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_data),
        .o_full  (mq_full),
        .i_pop   (back_en),
        .o_data  (mq_data),
        .o_empty (mq_empty)
    );

    // the back pipeline holds while the result queue is full
    assign back_en = !oq_full;

    tfu_back #(
        .SERIES_TERMS (SERIES_TERMS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (!mq_empty),
        .i_front (t_front'(mq_data)),
        .o_valid (b_valid),
        .o_item  (b_item)
    );

    tfu_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid && back_en),
        .i_data  (b_item),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (oq_data),
        .o_empty (empty)
    );

    assign o_item = t_out'(oq_data);

endmodule

`default_nettype wire

>>> rtl/core/tfu_checker.sv
// tfu_checker: port-level assertions for the trig function unit, bound to the top
// depends on tfu_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tfu_checker import tfu_pkg::*; (
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  empty,
    input wire  pop,
    input t_out o_item
);

    `TFU_ASSERT_RST(a_reset_empty, !i_rst_n |=> empty, "result queue not empty after reset")
    `TFU_ASSERT(a_status_code, !empty |-> (o_item.status == ST_OK || o_item.status == ST_SAT || o_item.status == ST_DIV0), "unknown status code")
    `TFU_ASSERT(a_div0_zero, (!empty && o_item.status == ST_DIV0) |-> (o_item.value == '0), "zero divisor item has nonzero value")
    `TFU_ASSERT(a_sat_limit, (!empty && o_item.status == ST_SAT) |-> (o_item.value == 32'h7fff_ffff || o_item.value == 32'h8000_0000), "saturated item not at a limit")
    `TFU_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_item)), "waiting item changed")

endmodule

bind taylor_trig_function_unit_top tfu_checker u_tfu_checker (.*);

`default_nettype wire
